### rtl/core/ptrf_pkg.sv
package ptrf_pkg;

    localparam int ADDR_W     = 48;
    localparam int ID_W       = 16;
    localparam int MAP_W      = 64;
    localparam int SLOT_IDX_W = 6;   // enough for the largest supported table
    localparam int SLOT_OUT_W = 4;

    typedef enum logic [1:0] {
        FN_UNICAST = 2'd0,
        FN_BCAST   = 2'd1,
        FN_JOIN    = 2'd2,
        FN_REMOVE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FETCH,
        ST_EXEC,
        ST_DONE
    } t_state;

    // Per-peer replay state kept in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]  last_uid;
        logic [ID_W-1:0]  bcast_base;
        logic [MAP_W-1:0] bcast_map;
        logic [ID_W-1:0]  join_base;
        logic [MAP_W-1:0] join_map;
    } t_peer_rec;

    // Result of one address scan over the table.
    typedef struct packed {
        logic                  done;
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic                  free;
        logic [SLOT_IDX_W-1:0] free_idx;
    } t_lkp_res;

    // Table update issued once the scan has finished.
    typedef struct packed {
        logic                  set;
        logic                  clr;
        logic [SLOT_IDX_W-1:0] idx;
    } t_tbl_cmd;

endpackage

### rtl/core/peer_table_replay_filter_core.sv
// Receive-side duplicate and replay filter over a table of peers.
// Input channel: i_valid / o_stall with i_func, i_peer_address and i_packet_id.
// A request is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_accept, o_peer_slot, o_peer_known,
// o_slot_allocated and o_table_full, one result per request, in order.
// The accept_join register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// Each request first walks the address table with a single 48-bit comparator,
// one slot per cycle, which sets the cost of a request. After that, ST_DECIDE
// picks or allocates a slot, ST_FETCH reads the slot's replay state, and ST_EXEC
// runs the sliding window check and writes the state back; ST_DONE then loads
// the output register. A new request is taken only once the last one has left
// ST_DONE, so one request is in flight at a time.
// When the receiver stalls, the finished result waits in the output register
// and a newer request holds in its final step until that register frees.
// Reset clears every slot's valid bit and the accept_join register; no
// clearing pass is needed because a slot's state is rewritten on allocation.
module peer_table_replay_filter_core #(
    parameter int PEER_SLOTS   = 16,
    parameter int BCAST_WINDOW = 32,
    parameter int JOIN_WINDOW  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_func,
    input  logic [ptrf_pkg::ADDR_W-1:0]      i_peer_address,
    input  logic [ptrf_pkg::ID_W-1:0]        i_packet_id,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_accept,
    output logic [ptrf_pkg::SLOT_OUT_W-1:0]  o_peer_slot,
    output logic                             o_peer_known,
    output logic                             o_slot_allocated,
    output logic                             o_table_full,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata
);

    localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

    // Control state.
    ptrf_pkg::t_state r_state, n_state;
    logic             r_out_valid;
    logic             r_accept_join;

    // Request and working registers.
    ptrf_pkg::t_func             r_func, n_func;
    logic [ptrf_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [ptrf_pkg::ID_W-1:0]   r_id, n_id;
    logic [IDX_W-1:0]            r_slot_idx, n_slot_idx;
    logic                        r_has_slot, n_has_slot;
    logic                        r_known, n_known;
    logic                        r_alloc, n_alloc;
    logic                        r_full, n_full;
    ptrf_pkg::t_peer_rec         r_rec, n_rec;
    logic [ptrf_pkg::ID_W-1:0]   r_dist, n_dist;
    logic                        r_acc, n_acc;

    // Output payload registers.
    logic                            r_out_accept;
    logic [ptrf_pkg::SLOT_OUT_W-1:0] r_out_slot;
    logic                            r_out_known;
    logic                            r_out_alloc;
    logic                            r_out_full;

    // Slot state memory.
    ptrf_pkg::t_peer_rec r_peer_mem [PEER_SLOTS];
    ptrf_pkg::t_peer_rec r_mem_q;
    logic [IDX_W-1:0]    w_rd_idx;
    logic                w_mem_we;

    ptrf_pkg::t_lkp_res w_lkp;
    ptrf_pkg::t_tbl_cmd w_cmd;
    logic               w_lkp_start;
    logic               w_load_out;

    logic [ptrf_pkg::MAP_W-1:0] w_win_map_in;
    logic [ptrf_pkg::ID_W-1:0]  w_win_size;
    logic                       w_win_acc;
    logic                       w_win_rebase;
    logic [ptrf_pkg::MAP_W-1:0] w_win_map;
    ptrf_pkg::t_peer_rec        w_new_rec;
    logic                       w_new_acc;
    logic [IDX_W+3:0]           w_slot_ext;

    ptrf_lookup #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lkp_start),
        .i_addr  (r_addr),
        .i_cmd   (w_cmd),
        .o_res   (w_lkp)
    );

    // The broadcast and join windows share one checker; the request kind picks the fields.
    assign w_win_map_in = (r_func == ptrf_pkg::FN_JOIN) ? r_rec.join_map : r_rec.bcast_map;
    assign w_win_size   = (r_func == ptrf_pkg::FN_JOIN) ? ptrf_pkg::ID_W'(JOIN_WINDOW)
                                                        : ptrf_pkg::ID_W'(BCAST_WINDOW);

    ptrf_window u_window (
        .i_dist   (r_dist),
        .i_map    (w_win_map_in),
        .i_size   (w_win_size),
        .o_accept (w_win_acc),
        .o_rebase (w_win_rebase),
        .o_map    (w_win_map)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptrf_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = ptrf_pkg::ST_SCAN;
                end
            end
            ptrf_pkg::ST_SCAN: begin
                if (w_lkp.done) begin
                    n_state = ptrf_pkg::ST_DECIDE;
                end
            end
            ptrf_pkg::ST_DECIDE: n_state = ptrf_pkg::ST_FETCH;
            ptrf_pkg::ST_FETCH:  n_state = ptrf_pkg::ST_EXEC;
            ptrf_pkg::ST_EXEC:   n_state = ptrf_pkg::ST_DONE;
            ptrf_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ptrf_pkg::ST_IDLE;
                end
            end
            default: n_state = ptrf_pkg::ST_IDLE;
        endcase
    end

    // Accept decision and updated slot state for the request in hand.
    always_comb begin
        w_new_rec = r_rec;
        w_new_acc = 1'b1;
        case (r_func)
            ptrf_pkg::FN_UNICAST: begin
                if (r_has_slot) begin
                    w_new_acc = (r_rec.last_uid != r_id);
                    w_new_rec.last_uid = r_id;
                end
            end
            ptrf_pkg::FN_BCAST: begin
                if (r_has_slot) begin
                    w_new_acc = w_win_acc;
                    w_new_rec.bcast_map = w_win_map;
                    if (w_win_rebase) begin
                        w_new_rec.bcast_base = r_id;
                    end
                end
            end
            ptrf_pkg::FN_JOIN: begin
                // Without a slot or with joins disabled the request is dropped,
                // but a freshly allocated slot still gets its cleared state.
                if (r_has_slot && r_accept_join) begin
                    w_new_acc = w_win_acc;
                    w_new_rec.join_map = w_win_map;
                    if (w_win_rebase) begin
                        w_new_rec.join_base = r_id;
                    end
                end else begin
                    w_new_acc = 1'b0;
                end
            end
            ptrf_pkg::FN_REMOVE: w_new_acc = 1'b1;
            default:             w_new_acc = 1'b1;
        endcase
    end

    // Sequencer outputs and datapath steps.
    always_comb begin
        n_func      = r_func;
        n_addr      = r_addr;
        n_id        = r_id;
        n_slot_idx  = r_slot_idx;
        n_has_slot  = r_has_slot;
        n_known     = r_known;
        n_alloc     = r_alloc;
        n_full      = r_full;
        n_rec       = r_rec;
        n_dist      = r_dist;
        n_acc       = r_acc;
        w_lkp_start = 1'b0;
        w_cmd       = '0;
        w_rd_idx    = r_slot_idx;
        w_mem_we    = 1'b0;
        w_load_out  = 1'b0;
        o_stall     = 1'b1;
        case (r_state)
            ptrf_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    w_lkp_start = 1'b1;
                    n_func      = ptrf_pkg::t_func'(i_func);
                    n_addr      = i_peer_address;
                    n_id        = i_packet_id;
                end
            end
            ptrf_pkg::ST_SCAN: begin
                w_lkp_start = 1'b0;
            end
            ptrf_pkg::ST_DECIDE: begin
                n_known    = 1'b0;
                n_alloc    = 1'b0;
                n_full     = 1'b0;
                n_has_slot = 1'b0;
                n_slot_idx = '0;
                if (r_func == ptrf_pkg::FN_REMOVE) begin
                    if (w_lkp.hit) begin
                        n_known    = 1'b1;
                        n_has_slot = 1'b1;
                        n_slot_idx = w_lkp.hit_idx[IDX_W-1:0];
                        w_cmd.clr  = 1'b1;
                        w_cmd.idx  = w_lkp.hit_idx;
                    end
                end else if (w_lkp.hit) begin
                    n_known    = 1'b1;
                    n_has_slot = 1'b1;
                    n_slot_idx = w_lkp.hit_idx[IDX_W-1:0];
                end else if (w_lkp.free) begin
                    n_alloc    = 1'b1;
                    n_has_slot = 1'b1;
                    n_slot_idx = w_lkp.free_idx[IDX_W-1:0];
                    w_cmd.set  = 1'b1;
                    w_cmd.idx  = w_lkp.free_idx;
                end else begin
                    n_full = 1'b1;
                end
                w_rd_idx = n_slot_idx;
            end
            ptrf_pkg::ST_FETCH: begin
                // A newly allocated slot starts from all-zero state.
                n_rec  = r_alloc ? '0 : r_mem_q;
                n_dist = r_id - ((r_func == ptrf_pkg::FN_JOIN) ? n_rec.join_base
                                                               : n_rec.bcast_base);
            end
            ptrf_pkg::ST_EXEC: begin
                n_acc    = w_new_acc;
                w_mem_we = r_has_slot && (r_func != ptrf_pkg::FN_REMOVE);
            end
            ptrf_pkg::ST_DONE: begin
                w_load_out = !r_out_valid || !i_stall;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_peer_mem[r_slot_idx] <= w_new_rec;
        end
        r_mem_q <= r_peer_mem[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ptrf_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_accept_join <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_accept_join <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_addr     <= n_addr;
        r_id       <= n_id;
        r_slot_idx <= n_slot_idx;
        r_has_slot <= n_has_slot;
        r_known    <= n_known;
        r_alloc    <= n_alloc;
        r_full     <= n_full;
        r_rec      <= n_rec;
        r_dist     <= n_dist;
        r_acc      <= n_acc;
    end

    // The reported slot is the low four bits of the table index, or zero without a slot.
    assign w_slot_ext = {4'b0000, r_slot_idx};

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_accept <= r_acc;
            r_out_slot   <= r_has_slot ? w_slot_ext[3:0] : '0;
            r_out_known  <= r_known;
            r_out_alloc  <= r_alloc;
            r_out_full   <= r_full;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_accept         = r_out_accept;
    assign o_peer_slot      = r_out_slot;
    assign o_peer_known     = r_out_known;
    assign o_slot_allocated = r_out_alloc;
    assign o_table_full     = r_out_full;

endmodule

### rtl/core/ptrf_lookup.sv
module ptrf_lookup #(
    parameter int PEER_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ptrf_pkg::ADDR_W-1:0]  i_addr,
    input  ptrf_pkg::t_tbl_cmd           i_cmd,
    output ptrf_pkg::t_lkp_res           o_res
);

    localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEER_SLOTS - 1);

    logic [ptrf_pkg::ADDR_W-1:0] r_addr_mem [PEER_SLOTS];
    logic [ptrf_pkg::ADDR_W-1:0] r_rd_q;
    logic [PEER_SLOTS-1:0]       r_valid;
    logic                        r_issue;
    logic [IDX_W-1:0]            r_rd_idx;
    logic                        r_cmp_vld;
    logic [IDX_W-1:0]            r_cmp_idx;
    logic                        r_done;
    logic                        r_hit;
    logic [IDX_W-1:0]            r_hit_idx;
    logic                        r_free;
    logic [IDX_W-1:0]            r_free_idx;
    logic [IDX_W-1:0]            w_cmd_idx;
    logic                        w_cmp_valid;

    assign w_cmd_idx   = i_cmd.idx[IDX_W-1:0];
    assign w_cmp_valid = r_valid[r_cmp_idx];

    // Address store: one write from the table update, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set) begin
            r_addr_mem[w_cmd_idx] <= i_addr;
        end
        r_rd_q <= r_addr_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_issue   <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            if (i_cmd.set) begin
                r_valid[w_cmd_idx] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_valid[w_cmd_idx] <= 1'b0;
            end

            r_cmp_vld <= r_issue;
            r_cmp_idx <= r_rd_idx;
            r_done    <= r_cmp_vld && (r_cmp_idx == LAST_IDX);

            if (i_start) begin
                r_issue  <= 1'b1;
                r_rd_idx <= '0;
                r_hit    <= 1'b0;
                r_free   <= 1'b0;
            end else if (r_issue) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end

            // The first matching slot and the lowest free slot win.
            if (r_cmp_vld) begin
                if (w_cmp_valid && (r_rd_q == i_addr) && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!w_cmp_valid && !r_free) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && w_cmp_valid && (r_rd_q == i_addr) && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp_vld && !w_cmp_valid && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    always_comb begin
        o_res.done     = r_done;
        o_res.hit      = r_hit;
        o_res.hit_idx  = ptrf_pkg::SLOT_IDX_W'(r_hit_idx);
        o_res.free     = r_free;
        o_res.free_idx = ptrf_pkg::SLOT_IDX_W'(r_free_idx);
    end

endmodule

### rtl/core/ptrf_window.sv
module ptrf_window (
    input  logic [ptrf_pkg::ID_W-1:0]  i_dist,
    input  logic [ptrf_pkg::MAP_W-1:0] i_map,
    input  logic [ptrf_pkg::ID_W-1:0]  i_size,
    output logic                       o_accept,
    output logic                       o_rebase,
    output logic [ptrf_pkg::MAP_W-1:0] o_map
);

    logic                       w_zero;
    logic                       w_inwin;
    logic [ptrf_pkg::ID_W-1:0]  w_dm1;
    logic [ptrf_pkg::MAP_W-1:0] w_bit;
    logic                       w_dup;
    logic                       w_far;

    always_comb begin
        w_zero  = (i_dist == '0);
        w_inwin = (i_dist <= i_size);
        w_dm1   = i_dist - 1'b1;
        w_bit   = ptrf_pkg::MAP_W'(1) << w_dm1[5:0];
        w_dup   = |(i_map & w_bit);
        w_far   = |w_dm1[ptrf_pkg::ID_W-1:6];

        o_accept = !w_zero && (!w_inwin || !w_dup);
        o_rebase = !w_zero && !w_inwin;

        if (w_zero) begin
            o_map = i_map;
        end else if (w_inwin) begin
            o_map = i_map | w_bit;
        end else if (w_far) begin
            // A jump of 65 or more ids forgets the whole history.
            o_map = ptrf_pkg::MAP_W'(1);
        end else begin
            o_map = (i_map << w_dm1[5:0]) | ptrf_pkg::MAP_W'(1);
        end
    end

endmodule

### tb/testbench.sv
module testbench;

    // The block runs with its default sizes; the local copies below must agree
    // with the parameters passed to the instance.
    localparam int PEER_SLOTS   = 16;
    localparam int BCAST_WINDOW = 32;
    localparam int JOIN_WINDOW  = 32;
    localparam int POOL_SIZE    = 20;

    // The drain wait before a register write and at the end of the run is set
    // comfortably above the time that a request takes through the block.
    localparam int DRAIN_CYCLES = PEER_SLOTS + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 195;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [1:0]                      i_func = ptrf_pkg::FN_UNICAST;
    logic [ptrf_pkg::ADDR_W-1:0]     i_peer_address = '0;
    logic [ptrf_pkg::ID_W-1:0]       i_packet_id = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_accept;
    logic [ptrf_pkg::SLOT_OUT_W-1:0] o_peer_slot;
    logic                            o_peer_known;
    logic                            o_slot_allocated;
    logic                            o_table_full;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_wdata = 1'b0;

    peer_table_replay_filter_core #(
        .PEER_SLOTS   (PEER_SLOTS),
        .BCAST_WINDOW (BCAST_WINDOW),
        .JOIN_WINDOW  (JOIN_WINDOW)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_peer_address   (i_peer_address),
        .i_packet_id      (i_packet_id),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_accept         (o_accept),
        .o_peer_slot      (o_peer_slot),
        .o_peer_known     (o_peer_known),
        .o_slot_allocated (o_slot_allocated),
        .o_table_full     (o_table_full),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Expected verdict for one request, in the order of the output ports.
    typedef struct packed {
        logic                            accept;
        logic [ptrf_pkg::SLOT_OUT_W-1:0] slot;
        logic                            known;
        logic                            alloc;
        logic                            full;
    } t_verdict;

    // Our own image of one table slot.
    typedef struct {
        bit                          live;
        logic [ptrf_pkg::ADDR_W-1:0] addr;
        logic [ptrf_pkg::ID_W-1:0]   last_uid;
        logic [ptrf_pkg::ID_W-1:0]   bc_base;
        logic [ptrf_pkg::MAP_W-1:0]  bc_map;
        logic [ptrf_pkg::ID_W-1:0]   jn_base;
        logic [ptrf_pkg::MAP_W-1:0]  jn_map;
    } t_peer_image;

    t_peer_image     peer_table [PEER_SLOTS];
    bit              join_enabled;
    t_verdict        pending_verdicts[$];
    t_verdict        head_verdict;

    // Traffic bookkeeping: a pool of senders, each with its own id streams.
    logic [ptrf_pkg::ADDR_W-1:0] sender_pool [POOL_SIZE];
    logic [ptrf_pkg::ID_W-1:0]   bc_head [POOL_SIZE];
    logic [ptrf_pkg::ID_W-1:0]   jn_head [POOL_SIZE];
    logic [ptrf_pkg::ID_W-1:0]   uc_last [POOL_SIZE];

    // When set, the matching side of the link runs without any idle cycles.
    bit tx_steady;
    bit rx_steady;
    bit hold_off_req;
    int held_cycles;

    int mismatch_count;
    int request_count;
    int result_count;
    int delivered_count;
    int dropped_count;
    int full_count;
    int cycle_count;

    // Idle lengths for both sides: mostly none or short, now and then long.
    function automatic int unsigned gap_len(bit steady);
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (steady || r < 50) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        return n;
    endfunction

    // Sliding bitmap window over the broadcast or the join stream of one slot.
    // The distance wraps at 16 bits, so an id far behind the base looks like a
    // large jump ahead and moves the window forward.
    function automatic bit window_admit(int s, bit is_join, logic [ptrf_pkg::ID_W-1:0] id);
        logic [ptrf_pkg::ID_W-1:0]  base;
        logic [ptrf_pkg::MAP_W-1:0] map;
        logic [ptrf_pkg::ID_W-1:0]  offset;
        int unsigned                span;
        int unsigned                shift;
        int unsigned                bitpos;
        bit                         ok;
        base   = is_join ? peer_table[s].jn_base : peer_table[s].bc_base;
        map    = is_join ? peer_table[s].jn_map  : peer_table[s].bc_map;
        span   = is_join ? JOIN_WINDOW : BCAST_WINDOW;
        offset = id - base;
        ok     = 1'b0;
        if (offset == 0) begin
            ok = 1'b0;
        end else if (offset <= span) begin
            bitpos = (int'(offset) - 1) % ptrf_pkg::MAP_W;
            if (!map[bitpos]) begin
                map[bitpos] = 1'b1;
                ok = 1'b1;
            end
        end else begin
            shift = int'(offset) - 1;
            if (shift >= ptrf_pkg::MAP_W) map = '0;
            else map = map << shift;
            map[0] = 1'b1;
            base = id;
            ok = 1'b1;
        end
        if (is_join) begin
            peer_table[s].jn_base = base;
            peer_table[s].jn_map  = map;
        end else begin
            peer_table[s].bc_base = base;
            peer_table[s].bc_map  = map;
        end
        return ok;
    endfunction

    // Works out the verdict for one accepted request and updates the table image.
    function automatic t_verdict predict_verdict(ptrf_pkg::t_func fn,
                                                 logic [ptrf_pkg::ADDR_W-1:0] addr,
                                                 logic [ptrf_pkg::ID_W-1:0] id);
        t_verdict v;
        int       hit;
        int       s;
        v   = '0;
        hit = -1;
        for (s = 0; s < PEER_SLOTS; s++) begin
            if (hit < 0 && peer_table[s].live && peer_table[s].addr == addr) hit = s;
        end
        if (fn == ptrf_pkg::FN_REMOVE) begin
            if (hit >= 0) begin
                v.known = 1'b1;
                peer_table[hit].live = 1'b0;
            end
            v.accept = 1'b1;
        end else begin
            if (hit >= 0) begin
                v.known = 1'b1;
            end else begin
                // A new sender takes the lowest free slot with its state cleared.
                for (s = 0; s < PEER_SLOTS; s++) begin
                    if (hit < 0 && !peer_table[s].live) hit = s;
                end
                if (hit >= 0) begin
                    peer_table[hit].live     = 1'b1;
                    peer_table[hit].addr     = addr;
                    peer_table[hit].last_uid = '0;
                    peer_table[hit].bc_base  = '0;
                    peer_table[hit].bc_map   = '0;
                    peer_table[hit].jn_base  = '0;
                    peer_table[hit].jn_map   = '0;
                    v.alloc = 1'b1;
                end else begin
                    v.full = 1'b1;
                end
            end
            case (fn)
                ptrf_pkg::FN_UNICAST: begin
                    if (hit < 0) begin
                        v.accept = 1'b1;
                    end else if (peer_table[hit].last_uid == id) begin
                        v.accept = 1'b0;
                    end else begin
                        peer_table[hit].last_uid = id;
                        v.accept = 1'b1;
                    end
                end
                ptrf_pkg::FN_BCAST: begin
                    if (hit < 0) v.accept = 1'b1;
                    else v.accept = window_admit(hit, 1'b0, id);
                end
                default: begin
                    // A join can only be checked against a slot, and only when enabled.
                    if (hit >= 0 && join_enabled) v.accept = window_admit(hit, 1'b1, id);
                    else v.accept = 1'b0;
                end
            endcase
        end
        if (hit >= 0) v.slot = ptrf_pkg::SLOT_OUT_W'(hit);
        return v;
    endfunction

    // Next id in one sender's broadcast or join stream: mostly small steps
    // forward, some replays of recent ids, and now and then a wide jump.
    function automatic logic [ptrf_pkg::ID_W-1:0] stream_id(int p, bit is_join);
        logic [ptrf_pkg::ID_W-1:0] head;
        logic [ptrf_pkg::ID_W-1:0] id;
        int unsigned               r;
        head = is_join ? jn_head[p] : bc_head[p];
        r = $urandom_range(0, 99);
        if (r < 20) begin
            id = head - ptrf_pkg::ID_W'($urandom_range(0, 40));
        end else if (r < 90) begin
            head = head + ptrf_pkg::ID_W'($urandom_range(1, 6));
            id = head;
        end else begin
            head = head + ptrf_pkg::ID_W'($urandom_range(33, 2000));
            id = head;
        end
        if (is_join) jn_head[p] = head;
        else bc_head[p] = head;
        return id;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("mismatch at cycle %0d, result %0d: %s", cycle_count, result_count, what);
    endtask

    // Offers one request after a random gap and holds it until the block takes
    // it. Valid is left high on return so that a back-to-back request follows
    // without a bubble.
    task automatic send_request(ptrf_pkg::t_func fn, logic [ptrf_pkg::ADDR_W-1:0] addr,
                                logic [ptrf_pkg::ID_W-1:0] id);
        int unsigned gap;
        gap = gap_len(tx_steady);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= fn;
        i_peer_address <= addr;
        i_packet_id    <= id;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_verdicts.push_back(predict_verdict(fn, addr, id));
        request_count++;
    endtask

    // The register is only written with the block idle: nothing in flight and
    // the pipeline given time to settle.
    task automatic write_accept_join(bit value);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        join_enabled = value;
    endtask

    // A newly allocated sender starts with all ids at zero, so id zero is a
    // duplicate on every stream. Joins are dropped while registration is off.
    task automatic test_fresh_peer();
        send_request(ptrf_pkg::FN_UNICAST, sender_pool[0], 16'h0000);
        send_request(ptrf_pkg::FN_UNICAST, sender_pool[0], 16'hFFFF);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[0], 16'h0000);
        send_request(ptrf_pkg::FN_JOIN, sender_pool[0], 16'h0007);
    endtask

    // Edges of the broadcast and join windows: the last bit inside the window,
    // a repeat, an advance by one past the window, an advance that clears the
    // bitmap, an id far behind that wraps into an advance, and join ids.
    task automatic test_window_edges();
        write_accept_join(1'b1);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[1], 16'd32);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[1], 16'd32);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[1], 16'd33);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[1], 16'd98);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[1], 16'd97);
        send_request(ptrf_pkg::FN_JOIN, sender_pool[1], 16'd1);
        send_request(ptrf_pkg::FN_JOIN, sender_pool[1], 16'd1);
        send_request(ptrf_pkg::FN_JOIN, sender_pool[1], 16'd0);
    endtask

    // Fills the remaining slots, then sends from an unknown sender: unicast and
    // broadcast pass unchecked, a join is dropped.
    task automatic test_table_full();
        int k;
        for (k = 2; k < PEER_SLOTS; k++) begin
            case (k % 3)
                0: send_request(ptrf_pkg::FN_UNICAST, sender_pool[k],
                                ptrf_pkg::ID_W'($urandom));
                1: send_request(ptrf_pkg::FN_BCAST, sender_pool[k],
                                ptrf_pkg::ID_W'($urandom));
                default: send_request(ptrf_pkg::FN_JOIN, sender_pool[k],
                                      ptrf_pkg::ID_W'($urandom));
            endcase
        end
        send_request(ptrf_pkg::FN_UNICAST, sender_pool[16], 16'h1234);
        send_request(ptrf_pkg::FN_BCAST, sender_pool[16], 16'h0001);
        send_request(ptrf_pkg::FN_JOIN, sender_pool[16], 16'h0001);
    endtask

    // Removal of a known and of an unknown sender, then reuse of the freed slot.
    task automatic test_remove_peer();
        send_request(ptrf_pkg::FN_REMOVE, sender_pool[0], 16'hFFFF);
        send_request(ptrf_pkg::FN_REMOVE, sender_pool[0], 16'h0000);
        send_request(ptrf_pkg::FN_UNICAST, sender_pool[17], 16'h0000);
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // back to back, so the block fills and has to stall its input.
    task automatic test_backpressure();
        int k;
        tx_steady    = 1'b1;
        hold_off_req = 1'b1;
        for (k = 0; k < 20; k++) begin
            send_request(ptrf_pkg::FN_UNICAST, sender_pool[k % 4],
                         ptrf_pkg::ID_W'($urandom));
        end
        tx_steady = 1'b0;
    endtask

    // Random traffic in phases with registration switched off and on. Most
    // requests come from the sender pool with well-formed id streams; a few
    // come from random addresses, usually removed again right after.
    task automatic test_random_traffic();
        int                          phase;
        int                          n;
        int                          p;
        int unsigned                 r;
        ptrf_pkg::t_func             fn;
        logic [ptrf_pkg::ADDR_W-1:0] addr;
        logic [ptrf_pkg::ID_W-1:0]   id;
        for (phase = 0; phase < 4; phase++) begin
            write_accept_join(phase[0]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // One phase starts with a stretch where neither side idles.
                tx_steady = (phase == 1 && n < 60);
                rx_steady = (phase == 1 && n < 60);
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    addr = {16'($urandom), 32'($urandom)};
                    r = $urandom_range(0, 2);
                    fn = (r == 0) ? ptrf_pkg::FN_UNICAST
                       : (r == 1) ? ptrf_pkg::FN_BCAST : ptrf_pkg::FN_JOIN;
                    send_request(fn, addr, ptrf_pkg::ID_W'($urandom));
                    if ($urandom_range(0, 3) != 0) begin
                        send_request(ptrf_pkg::FN_REMOVE, addr, ptrf_pkg::ID_W'($urandom));
                    end
                end else begin
                    p = $urandom_range(0, POOL_SIZE - 1);
                    r = $urandom_range(0, 99);
                    if (r < 6) begin
                        fn = ptrf_pkg::FN_REMOVE;
                        id = ptrf_pkg::ID_W'($urandom);
                    end else if (r < 36) begin
                        fn = ptrf_pkg::FN_UNICAST;
                        if ($urandom_range(0, 3) == 0) id = uc_last[p];
                        else id = ptrf_pkg::ID_W'($urandom);
                        uc_last[p] = id;
                    end else if (r < 70) begin
                        fn = ptrf_pkg::FN_BCAST;
                        id = stream_id(p, 1'b0);
                    end else begin
                        fn = ptrf_pkg::FN_JOIN;
                        id = stream_id(p, 1'b1);
                    end
                    send_request(fn, sender_pool[p], id);
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // The receiver stalls at random. A hold-off request from a test makes it
    // stall for a long stretch, counted here.
    initial begin : receiver
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) begin
                    @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end else begin
                n = gap_len(rx_steady);
                if (n != 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    // Every result taken from the block is compared with the oldest verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
            end else begin
                head_verdict = pending_verdicts.pop_front();
                if (o_accept !== head_verdict.accept)
                    report_mismatch($sformatf("accept %b, expected %b",
                                              o_accept, head_verdict.accept));
                if (o_peer_slot !== head_verdict.slot)
                    report_mismatch($sformatf("peer_slot %0d, expected %0d",
                                              o_peer_slot, head_verdict.slot));
                if (o_peer_known !== head_verdict.known)
                    report_mismatch($sformatf("peer_known %b, expected %b",
                                              o_peer_known, head_verdict.known));
                if (o_slot_allocated !== head_verdict.alloc)
                    report_mismatch($sformatf("slot_allocated %b, expected %b",
                                              o_slot_allocated, head_verdict.alloc));
                if (o_table_full !== head_verdict.full)
                    report_mismatch($sformatf("table_full %b, expected %b",
                                              o_table_full, head_verdict.full));
                if (head_verdict.full) full_count++;
                if (head_verdict.accept) delivered_count++;
                else dropped_count++;
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int k;
        // Sender pool: the all-zero and all-one addresses, walking ones, a few
        // random ones. The first sixteen fill the table during the directed tests.
        sender_pool[0] = '0;
        sender_pool[1] = '1;
        for (k = 2; k < 16; k++) sender_pool[k] = ptrf_pkg::ADDR_W'(1) << (k * 3 - 5);
        sender_pool[16] = 48'h8000_0000_0001;
        sender_pool[17] = 48'h5555_AAAA_5555;
        for (k = 18; k < POOL_SIZE; k++) sender_pool[k] = {16'($urandom), 32'($urandom)};
        for (k = 0; k < POOL_SIZE; k++) begin
            bc_head[k] = '0;
            jn_head[k] = '0;
            uc_last[k] = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fresh_peer();
        test_window_edges();
        test_table_full();
        test_remove_peer();
        test_backpressure();
        test_random_traffic();

        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked: %0d delivered, %0d dropped",
                 request_count, result_count, delivered_count, dropped_count);
        $display("%0d with a full table, registration toggled across phases, %0s %0d",
                 full_count, "one long receiver hold-off, mismatches:", mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ptrf_pkg.sv
rtl/core/ptrf_lookup.sv
rtl/core/ptrf_window.sv
rtl/core/peer_table_replay_filter_core.sv
tb/testbench.sv
